// File: hdl/reuse_distance_profiler_unit_defines.svh
// ----------------------------------------------------------------------------
// reuse_distance_profiler_unit_defines
// Assertion macros shared by the reuse distance profiler RTL.
// ----------------------------------------------------------------------------
`ifndef REUSE_DISTANCE_PROFILER_UNIT_DEFINES_SVH
`define REUSE_DISTANCE_PROFILER_UNIT_DEFINES_SVH

// Check that holds on every rising clock edge, reset included.
`define RDP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

// Implication checked outside reset only.
`define RDP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

// File: hdl/rdp_pkg.sv
// ----------------------------------------------------------------------------
// rdp_pkg
// Beat types and widths for the reuse distance profiler.
// ----------------------------------------------------------------------------
`default_nettype none

package rdp_pkg;

    localparam int ADDR_W  = 10;
    localparam int COUNT_W = 16;
    localparam int DIST_W  = 10;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] access_count;
    } t_in_beat;

    typedef struct packed {
        logic               cold_miss;
        logic [DIST_W-1:0]  distance;
        logic [COUNT_W-1:0] extra_repeats;
    } t_out_beat;

    // Lookup wave travelling down the stack, one cell per cycle while the row is enabled.
    typedef struct packed {
        logic              vld;     // beat present in this stage
        logic              active;  // still searching / shifting
        logic [ADDR_W-1:0] addr;    // address being looked up
        logic [ADDR_W-1:0] carry;   // entry displaced from the cell above
        t_out_beat         res;
    } t_wave;

endpackage

`default_nettype wire

// File: hdl/rdp_cell.sv
// ----------------------------------------------------------------------------
// rdp_cell
// One position of the recency stack. Compares the passing lookup against its
// entry, takes the displaced entry from above and hands its own one down.
// ----------------------------------------------------------------------------
`default_nettype none

module rdp_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  rdp_pkg::t_wave       i_wave,
    output rdp_pkg::t_wave       o_wave,
    output logic                 o_occ
);

    logic                        r_occ;
    logic                        n_occ;
    logic [rdp_pkg::ADDR_W-1:0]  r_entry;
    logic [rdp_pkg::ADDR_W-1:0]  n_entry;
    rdp_pkg::t_wave              r_wave;
    rdp_pkg::t_wave              n_wave;

    always_comb begin
        n_wave  = i_wave;
        n_entry = r_entry;
        n_occ   = r_occ;
        if (i_wave.vld && i_wave.active) begin
            n_entry = i_wave.carry;
            if (!r_occ) begin
                // first empty slot: stack grows, address was not present
                n_occ         = 1'b1;
                n_wave.active = 1'b0;
            end else if (r_entry == i_wave.addr) begin
                n_wave.active        = 1'b0;
                n_wave.res.cold_miss = 1'b0;
                n_wave.res.distance  = rdp_pkg::DIST_W'(CELL_IDX);
            end else begin
                n_wave.carry = r_entry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ  <= 1'b0;
            r_wave <= '0;
        end else if (i_en) begin
            r_occ  <= n_occ;
            r_wave <= n_wave;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_entry <= n_entry;
        end
    end

    assign o_wave = r_wave;
    assign o_occ  = r_occ;

endmodule

`default_nettype wire

// File: hdl/reuse_distance_profiler_unit.sv
// ----------------------------------------------------------------------------
// reuse_distance_profiler_unit
// LRU stack distance of an address trace, built as a row of stack cells.
// ----------------------------------------------------------------------------
//  channel | dir | handshake                  | payload
//  in      | in  | i_in_valid / o_in_ready    | i_in_data  (addr, access_count)
//  out     | out | o_out_valid / i_out_ready  | o_out_data (cold_miss, distance,
//          |     |                            |             extra_repeats)
//
//  One beat enters per cycle while the output is not stalled; each beat walks
//  the cell row one cell per cycle, and its result is registered at the row end.
//  Latency is set by the length of the cell row, throughput by one cell step.
//  Reset empties the stack (occupancy bits cleared).
//  A stalled output freezes the whole row and holds o_in_ready low.
// ----------------------------------------------------------------------------
`default_nettype none
`include "reuse_distance_profiler_unit_defines.svh"

module reuse_distance_profiler_unit #(
    parameter int ADDR_COUNT = 1024
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  rdp_pkg::t_in_beat   i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output rdp_pkg::t_out_beat  o_out_data
);

    logic                  w_en;
    logic                  w_in_range;
    rdp_pkg::t_wave        w_head;
    rdp_pkg::t_wave        w_chain [ADDR_COUNT+1];
    logic [ADDR_COUNT-1:0] w_occ;
    logic                  r_out_valid;
    rdp_pkg::t_out_beat    r_out_data;

    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    assign w_in_range = 32'(i_in_data.addr) < 32'(ADDR_COUNT);

    always_comb begin
        w_head.vld               = i_in_valid;
        w_head.active            = w_in_range;
        w_head.addr              = i_in_data.addr;
        w_head.carry             = i_in_data.addr;
        w_head.res.cold_miss     = 1'b1;
        w_head.res.distance      = '0;
        w_head.res.extra_repeats = (i_in_data.access_count != '0)
                                 ? i_in_data.access_count - rdp_pkg::COUNT_W'(1) : '0;
    end

    assign w_chain[0] = w_head;

    for (genvar k = 0; k < ADDR_COUNT; k++) begin : g_cell
        rdp_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_wave  (w_chain[k]),
            .o_wave  (w_chain[k+1]),
            .o_occ   (w_occ[k])
        );
    end

    // a wave still searching at the bottom was a miss on a full stack
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_chain[ADDR_COUNT].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= w_chain[ADDR_COUNT].res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `RDP_ASSERT_IMPL(a_reset_no_beat, i_clk, i_rst_n, !$past(i_rst_n), !o_out_valid, "out beat after reset")
    `RDP_ASSERT_IMPL(a_cold_dist_zero, i_clk, i_rst_n, o_out_valid && o_out_data.cold_miss, o_out_data.distance == '0, "cold miss with nonzero distance")
    `RDP_ASSERT_IMPL(a_occ_contiguous, i_clk, i_rst_n, 1'b1, ((w_occ + ADDR_COUNT'(1)) & w_occ) == '0, "stack occupancy has a hole")
    `RDP_ASSERT_IMPL(a_hit_in_stack, i_clk, i_rst_n, o_out_valid && !o_out_data.cold_miss, 32'(o_out_data.distance) < $countones(w_occ), "hit distance beyond stack fill")

endmodule

`default_nettype wire

// File: bench/tb_reuse_distance_profiler_unit.sv
// ----------------------------------------------------------------------------
// tb_reuse_distance_profiler_unit
// Drives address trace beats into the profiler and checks each result beat
// against an LRU stack kept in the bench. The stimulus covers field extremes,
// a full sweep of the address space and a mix of hot, deep and oldest
// re-accesses, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_reuse_distance_profiler_unit;

    localparam int LRU_DEPTH  = 1024;
    localparam int ROW_CYCLES = LRU_DEPTH + 1;

    typedef struct {
        rdp_pkg::t_in_beat beat;
        bit                drain;    // hold this beat back until all results are in
    } t_trace_rec;

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               in_valid  = 1'b0;
    rdp_pkg::t_in_beat  in_data   = '0;
    logic               out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    rdp_pkg::t_out_beat o_out_data;

    t_trace_rec                 trace_q[$];
    rdp_pkg::t_out_beat         lru_expect_q[$];
    logic [rdp_pkg::ADDR_W-1:0] lru_stack[$];   // bench copy of the recency stack
    logic [rdp_pkg::ADDR_W-1:0] gen_recency[$]; // recency order as generated, for picks
    bit                         touched[LRU_DEPTH];

    bit in_fire      = 1'b0;
    int tx_gap       = 0;
    int tx_calm      = 0;
    int rx_gap       = 0;
    int rx_calm      = 0;
    int rx_hold      = 0;
    bit rx_held      = 1'b0;
    int results_seen = 0;
    int errors       = 0;

    reuse_distance_profiler_unit #(
        .ADDR_COUNT(LRU_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Mostly no gap, some short, a few long; now and then a calm stretch.
    function automatic int draw_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 70) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [rdp_pkg::COUNT_W-1:0] rand_count();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r == 2) return 16'd1;
        return rdp_pkg::COUNT_W'($urandom_range(0, 65535));
    endfunction

    // Stack distance lookup; an in-range address moves to the top afterwards.
    task automatic lru_lookup(input rdp_pkg::t_in_beat b, output rdp_pkg::t_out_beat r);
        int pos;
        pos = -1;
        r.cold_miss     = 1'b1;
        r.distance      = '0;
        r.extra_repeats = (b.access_count == 0) ? '0 : b.access_count - 1'b1;
        if (b.addr < LRU_DEPTH) begin
            for (int i = 0; i < lru_stack.size(); i++) begin
                if (pos < 0 && lru_stack[i] == b.addr) pos = i;
            end
            if (pos >= 0) begin
                r.cold_miss = 1'b0;
                r.distance  = rdp_pkg::DIST_W'(pos);
                lru_stack.delete(pos);
            end else if (lru_stack.size() >= LRU_DEPTH) begin
                lru_stack.pop_back();
            end
            lru_stack.push_front(b.addr);
        end
    endtask

    task automatic add_access(input logic [rdp_pkg::ADDR_W-1:0] a,
                              input logic [rdp_pkg::COUNT_W-1:0] cnt,
                              input bit drain);
        t_trace_rec rec;
        for (int i = 0; i < gen_recency.size(); i++) begin
            if (gen_recency[i] == a) begin
                gen_recency.delete(i);
                break;
            end
        end
        gen_recency.push_front(a);
        touched[a]            = 1'b1;
        rec.beat.addr         = a;
        rec.beat.access_count = cnt;
        rec.drain             = drain;
        trace_q.insert(trace_q.size(), rec);
    endtask

    // Result check first, then prediction of the beat taken in this cycle.
    always @(posedge i_clk) begin : scoreboard
        rdp_pkg::t_out_beat want;
        if (i_rst_n) begin
            if (o_out_valid && out_ready) begin
                results_seen++;
                rx_gap = draw_gap(rx_calm);
                if (lru_expect_q.size() == 0) begin
                    $error("result beat with nothing expected: %p", o_out_data);
                    errors++;
                end else begin
                    want = lru_expect_q.pop_front();
                    if (o_out_data.cold_miss !== want.cold_miss) begin
                        $error("cold_miss: expected %0d, actual %0d",
                               want.cold_miss, o_out_data.cold_miss);
                        errors++;
                    end
                    if (o_out_data.distance !== want.distance) begin
                        $error("distance: expected %0d, actual %0d",
                               want.distance, o_out_data.distance);
                        errors++;
                    end
                    if (o_out_data.extra_repeats !== want.extra_repeats) begin
                        $error("extra_repeats: expected %0d, actual %0d",
                               want.extra_repeats, o_out_data.extra_repeats);
                        errors++;
                    end
                end
            end
            in_fire = in_valid && o_in_ready;
            if (in_fire) begin
                lru_lookup(in_data, want);
                lru_expect_q.insert(lru_expect_q.size(), want);
                tx_gap = draw_gap(tx_calm);
            end
        end else begin
            in_fire = 1'b0;
        end
    end

    // Input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_fire) begin
            if (tx_gap > 0) begin
                tx_gap--;
                in_valid <= 1'b0;
            end else if (trace_q.size() > 0 &&
                         !(trace_q[0].drain && lru_expect_q.size() != 0)) begin
                in_valid <= 1'b1;
                in_data  <= trace_q[0].beat;
                void'(trace_q.pop_front());
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output ready; one long hold-off early on so the row backs up.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            out_ready <= 1'b0;
        end else if (!rx_held && results_seen >= 100) begin
            rx_held = 1'b1;
            rx_hold = 2999;
            out_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    initial begin : stimulus
        logic [rdp_pkg::ADDR_W-1:0] fresh[$];
        logic [rdp_pkg::ADDR_W-1:0] tmp;
        logic [rdp_pkg::ADDR_W-1:0] a;
        int                         j;
        int                         mode;

        // directed: extremes, zero count, immediate repeats, short reuse
        add_access(10'd0,    16'd1,     1'b0);
        add_access(10'd0,    16'd0,     1'b0);
        add_access(10'd1023, 16'hFFFF,  1'b0);
        add_access(10'd0,    16'd2,     1'b0);
        add_access(10'd1023, 16'd1,     1'b0);
        add_access(10'h155,  16'h5555,  1'b0);
        add_access(10'h2AA,  16'hAAAA,  1'b0);
        add_access(10'h155,  16'h8000,  1'b0);
        add_access(10'h2AA,  16'h7FFF,  1'b0);
        for (int i = 1; i <= 8; i++)
            add_access(rdp_pkg::ADDR_W'(i), rdp_pkg::COUNT_W'(i), 1'b0);
        add_access(10'd0,    16'd3,     1'b0);
        add_access(10'd1023, 16'hFFFE,  1'b0);
        add_access(10'd1023, 16'd0,     1'b0);
        add_access(10'h2AA,  16'd1,     1'b0);

        // sweep the rest of the address space in shuffled order
        for (int i = 0; i < LRU_DEPTH; i++) begin
            if (!touched[i]) fresh.insert(fresh.size(), rdp_pkg::ADDR_W'(i));
        end
        for (int i = fresh.size() - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = fresh[i];
            fresh[i] = fresh[j];
            fresh[j] = tmp;
        end
        foreach (fresh[i]) add_access(fresh[i], rand_count(), i == 0);

        // full stack: oldest, random depth, hot and arbitrary re-accesses
        for (int n = 0; n < 320; n++) begin
            mode = $urandom_range(0, 99);
            if (mode < 15)
                a = gen_recency[gen_recency.size() - 1];
            else if (mode < 50)
                a = gen_recency[$urandom_range(0, gen_recency.size() - 1)];
            else if (mode < 80)
                a = gen_recency[$urandom_range(0, 3)];
            else
                a = rdp_pkg::ADDR_W'($urandom_range(0, LRU_DEPTH - 1));
            add_access(a, rand_count(), n == 0);
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (trace_q.size() != 0 || in_valid || lru_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (ROW_CYCLES + 100) @(posedge i_clk);

        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #16_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
